// File: sv/bca_pkg.sv
// bca_pkg: shared types, constants and helpers of the barometer compensation averager
// no dependencies
`default_nettype none

package bca_pkg;

    localparam int AVG_DEPTH_DEF = 16;
    localparam int PRES_W        = 24;
    localparam int TEMP_W        = 11;
    localparam int VAL_W         = 25;
    localparam int ACC_W         = 64;
    localparam int DIG_B_W       = 20;
    localparam int CFG_DATA_W    = 20;
    localparam int CFG_ADDR_W    = 3;
    localparam int S_DATA_W      = 32;
    localparam int M_DATA_W      = 72;

    localparam logic signed [ACC_W-1:0] P_MAX      = 64'sd655360000000;
    localparam logic signed [ACC_W-1:0] T_MIN      = -64'sd13107200;
    localparam logic signed [ACC_W-1:0] T_MAX      = 64'sd39321600;
    localparam logic signed [ACC_W-1:0] T_BASE     = 64'sd16384000;
    localparam logic signed [ACC_W-1:0] BASE_SCALE = 64'sd6553600;
    localparam logic signed [16:0]      D1_OFFSET  = 17'sd7168;
    localparam logic signed [13:0]      C4_OFFSET  = 14'sd1024;
    localparam logic signed [DIG_B_W-1:0] P_GAIN   = 20'sd1000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SENS, REG_OFF, REG_SENS_TEMP, REG_OFF_TEMP,
        REG_REF_TEMP, REG_TEMP_GAIN, REG_PRES_BASE, REG_CURVE
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] sens;
        logic [12:0] offset;
        logic [11:0] sens_temp;
        logic [12:0] offset_temp;
        logic [15:0] ref_temp;
        logic [14:0] temp_gain;
        logic [11:0] pres_base;
        logic [19:0] curve;
    } cfg_t;

    typedef struct packed {
        logic               p_ok;
        logic [PRES_W-1:0]  p;
        logic               t_ok;
        logic signed [TEMP_W-1:0] t;
    } item_t;

    typedef enum logic [1:0] {C_IDLE, C_MUL, C_POST, C_PUSH} comp_state_t;

    typedef enum logic [2:0] {OP_SQ, OP_CORR, OP_OFF, OP_SENS, OP_X, OP_P, OP_T} comp_op_t;

    typedef enum logic [2:0] {A_IDLE, A_READ, A_UPD, A_FILL, A_DIV, A_OUT} avg_state_t;

    // arithmetic shift right that truncates toward zero
    function automatic logic signed [ACC_W-1:0] sra_tz(input logic signed [ACC_W-1:0] v,
                                                        input logic [5:0] sh);
        logic signed [ACC_W-1:0] bias;
        bias = v[ACC_W-1] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
        return (v + bias) >>> sh;
    endfunction

endpackage

`default_nettype wire

// File: sv/bca_comp.sv
// bca_comp: front part, evaluates the calibration polynomial with a digit-serial multiplier
// and range-checks the results; depends on bca_pkg
`default_nettype none

module bca_comp (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire bca_pkg::cfg_t cfg,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [15:0]  d1_in,
    input  wire logic [15:0]  d2_in,
    output bca_pkg::item_t    item,
    output logic              item_valid,
    input  wire logic         item_ready
);
    import bca_pkg::*;

    comp_state_t state_reg, state_next;
    comp_op_t    op_reg;
    logic [2:0]  cnt_reg;
    logic signed [ACC_W-1:0]   a_reg, acc_reg, dut_reg, off_reg, p_reg, t_reg;
    logic signed [DIG_B_W-1:0] b_reg;
    logic signed [16:0] d_reg;
    logic [15:0]        d1_reg;

    logic signed [16:0]        d_new, d1m;
    logic signed [13:0]        c4m;
    logic signed [4:0]         dig;
    logic signed [ACC_W-1:0]   part, dut_new, sens_new, x_new, t_q;
    logic [ACC_W-1:0]          corr;
    logic signed [ACC_W-1:0]   a_load;
    logic signed [DIG_B_W-1:0] b_load;
    logic [5:0]  ca, cb;
    logic [3:0]  cs, ds;

    assign ca = cfg.curve[5:0];
    assign cb = cfg.curve[11:6];
    assign cs = cfg.curve[15:12];
    assign ds = cfg.curve[19:16];

    assign d_new = $signed({1'b0, d2_in}) - $signed({1'b0, cfg.ref_temp});
    assign d1m   = $signed({1'b0, d1_reg}) - D1_OFFSET;
    assign c4m   = $signed({1'b0, cfg.offset_temp}) - C4_OFFSET;

    // top digit of the multiplier carries the sign
    assign dig  = (cnt_reg == 3'd4) ? $signed({b_reg[3], b_reg[3:0]}) : $signed({1'b0, b_reg[3:0]});
    assign part = a_reg * dig;

    assign corr     = {acc_reg[ACC_W-3:0], 2'b00} >> cs;
    assign dut_new  = $signed({{31{d_reg[16]}}, d_reg, 16'b0}) - $signed(corr);
    assign sens_new = $signed({32'b0, cfg.sens, 16'b0}) + sra_tz(acc_reg, 6'd10);
    assign x_new    = sra_tz(acc_reg, 6'd14) - off_reg;

    always_comb begin
        a_load = acc_reg;
        b_load = '0;
        case (op_reg)
            OP_SQ: begin
                a_load = acc_reg;
                b_load = {14'b0, (d_reg > 17'sd0) ? ca : cb};
            end
            OP_CORR: begin
                a_load = dut_new;
                b_load = {{6{c4m[13]}}, c4m};
            end
            OP_OFF: begin
                a_load = dut_reg;
                b_load = {8'b0, cfg.sens_temp};
            end
            OP_SENS: begin
                a_load = sens_new;
                b_load = {{3{d1m[16]}}, d1m};
            end
            OP_X: begin
                a_load = x_new;
                b_load = P_GAIN;
            end
            OP_P: begin
                a_load = dut_reg;
                b_load = {5'b0, cfg.temp_gain};
            end
            default: begin
                a_load = acc_reg;
                b_load = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (in_valid) state_next = C_MUL;
            C_MUL:  if (cnt_reg == 3'd4) state_next = C_POST;
            C_POST: state_next = (op_reg == OP_T) ? C_PUSH : C_MUL;
            C_PUSH: if (item_ready) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            C_IDLE: begin
                d_reg   <= d_new;
                d1_reg  <= d1_in;
                op_reg  <= OP_SQ;
                cnt_reg <= 3'd0;
                acc_reg <= '0;
                a_reg   <= {{47{d_new[16]}}, d_new};
                b_reg   <= {{3{d_new[16]}}, d_new};
            end
            C_MUL: begin
                acc_reg <= acc_reg + part;
                a_reg   <= a_reg <<< 4;
                b_reg   <= b_reg >>> 4;
                cnt_reg <= cnt_reg + 3'd1;
            end
            C_POST: begin
                case (op_reg)
                    OP_CORR: dut_reg <= dut_new;
                    OP_OFF:  off_reg <= ($signed({35'b0, cfg.offset, 16'b0})
                                         + sra_tz(acc_reg, 6'd14)) <<< 2;
                    OP_P:    p_reg <= sra_tz(acc_reg, 6'd5)
                                      + $signed({52'b0, cfg.pres_base}) * BASE_SCALE;
                    OP_T:    t_reg <= T_BASE + sra_tz(acc_reg, 6'd16)
                                      - sra_tz(dut_reg, {2'b0, ds});
                    default: ;
                endcase
                a_reg   <= a_load;
                b_reg   <= b_load;
                acc_reg <= '0;
                cnt_reg <= 3'd0;
                op_reg  <= comp_op_t'(op_reg + 3'd1);
            end
            default: ;
        endcase
    end

    assign t_q = sra_tz(t_reg, 6'd16);

    always_comb begin
        item.p_ok = (p_reg >= 64'sd0) && (p_reg <= P_MAX);
        item.p    = item.p_ok ? p_reg[16 +: PRES_W] : '0;
        item.t_ok = (t_reg >= T_MIN) && (t_reg <= T_MAX);
        item.t    = item.t_ok ? t_q[TEMP_W-1:0] : '0;
    end

    assign in_ready   = (state_reg == C_IDLE);
    assign item_valid = (state_reg == C_PUSH);

endmodule

`default_nettype wire

// File: sv/bca_fifo.sv
// bca_fifo: two-entry queue between the compensation front and the averaging back
// depends on bca_pkg
`default_nettype none

module bca_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire bca_pkg::item_t wr_item,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    output bca_pkg::item_t     rd_item,
    output logic               rd_valid,
    input  wire logic          rd_ready
);
    import bca_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/bca_avg.sv
// bca_avg: back part, ring averages for pressure and temperature and the output register
// depends on bca_pkg
`default_nettype none

module bca_avg #(
    parameter int AVG_DEPTH = bca_pkg::AVG_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire bca_pkg::item_t item,
    input  wire logic          item_valid,
    output logic               item_ready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [bca_pkg::M_DATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser
);
    import bca_pkg::*;

    localparam int IDX_W  = $clog2(AVG_DEPTH);
    localparam int ADDR_W = IDX_W + 1;
    localparam int MEM_D  = 2 ** ADDR_W;
    localparam int SUM_W  = VAL_W + IDX_W + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int RCP_SH = MAG_W + IDX_W;
    localparam int PROD_W = RCP_SH + MAG_W;
    // rounded-up reciprocal of the depth, exact floor for every sum magnitude
    localparam logic [63:0] RCP = ((64'd1 << RCP_SH) + 64'(AVG_DEPTH - 1)) / 64'(AVG_DEPTH);

    avg_state_t state_reg, state_next;
    item_t      item_reg;
    logic       ch_reg;
    logic       jump_reg;
    logic signed [VAL_W-1:0] v_reg;
    logic signed [SUM_W-1:0] sum_reg  [2];
    logic signed [VAL_W-1:0] mean_reg [2];
    logic [IDX_W-1:0]        slot_reg [2];
    logic [IDX_W-1:0]        idx_reg;
    logic [MEM_D-1:0]        vbit_reg;
    logic signed [VAL_W-1:0] ring_mem [MEM_D];
    logic signed [VAL_W-1:0] rdata_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_data_reg;
    logic [1:0]              m_user_reg;

    logic                    ok_cur, jump_cur, mem_we, last_fill, out_load;
    logic signed [VAL_W-1:0] v_cur, m_cur, old_val;
    logic signed [VAL_W:0]   diff;
    logic [VAL_W:0]          absd;
    logic [VAL_W+7:0]        d50;
    logic [ADDR_W-1:0]       rd_addr, wr_addr;
    logic signed [SUM_W-1:0] sum_upd;
    logic [PROD_W-1:0]       prod;
    logic [MAG_W-1:0]        quo;
    logic signed [VAL_W-1:0] quo_val;

    assign ok_cur = ch_reg ? item_reg.t_ok : item_reg.p_ok;
    assign v_cur  = ch_reg ? VAL_W'(item_reg.t) : $signed({1'b0, item_reg.p});
    assign m_cur  = mean_reg[ch_reg];

    // jump when the new value leaves two percent of a positive mean, or is nonzero while the mean is zero
    assign diff     = $signed({v_cur[VAL_W-1], v_cur}) - $signed({m_cur[VAL_W-1], m_cur});
    assign absd     = diff[VAL_W] ? $unsigned(-diff) : $unsigned(diff);
    assign d50      = (VAL_W+8)'(absd) * (VAL_W+8)'(50);
    assign jump_cur = (m_cur > 0) ? (d50 > (VAL_W+8)'($unsigned(m_cur)))
                                  : ((m_cur == 0) && (v_cur != 0));

    assign rd_addr   = {ch_reg, slot_reg[ch_reg]};
    assign wr_addr   = (state_reg == A_FILL) ? {ch_reg, idx_reg} : rd_addr;
    assign mem_we    = (state_reg == A_FILL) || ((state_reg == A_UPD) && !jump_reg);
    assign old_val   = vbit_reg[rd_addr] ? rdata_reg : '0;
    assign sum_upd   = sum_reg[ch_reg] - SUM_W'(old_val) + SUM_W'(v_reg);
    assign last_fill = (idx_reg == IDX_W'(AVG_DEPTH - 1));
    // divide the sum magnitude by the ring depth with one reciprocal multiplication
    assign prod      = PROD_W'(mag_reg) * PROD_W'(RCP[SUM_W-1:0]);
    assign quo       = prod[RCP_SH +: MAG_W];
    assign quo_val   = $signed(VAL_W'(quo));
    assign out_load  = (state_reg == A_OUT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE: if (item_valid) state_next = A_READ;
            A_READ: begin
                if (ok_cur) state_next = A_UPD;
                else if (ch_reg) state_next = A_OUT;
            end
            A_UPD:  state_next = jump_reg ? A_FILL : A_DIV;
            A_FILL: if (last_fill) state_next = ch_reg ? A_OUT : A_READ;
            A_DIV:  state_next = ch_reg ? A_OUT : A_READ;
            A_OUT:  if (out_load) state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) ring_mem[wr_addr] <= v_reg;
        rdata_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= A_IDLE;
            ch_reg      <= 1'b0;
            vbit_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                sum_reg[i]  <= '0;
                mean_reg[i] <= '0;
                slot_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (mem_we) vbit_reg[wr_addr] <= 1'b1;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                A_IDLE: ch_reg <= 1'b0;
                A_READ: if (!ok_cur && !ch_reg) ch_reg <= 1'b1;
                A_UPD: begin
                    if (jump_reg) begin
                        sum_reg[ch_reg] <= '0;
                    end else begin
                        sum_reg[ch_reg]  <= sum_upd;
                        slot_reg[ch_reg] <= (slot_reg[ch_reg] == IDX_W'(AVG_DEPTH - 1))
                                            ? '0 : slot_reg[ch_reg] + 1'b1;
                    end
                end
                A_FILL: begin
                    sum_reg[ch_reg] <= sum_reg[ch_reg] + SUM_W'(v_reg);
                    if (last_fill) begin
                        mean_reg[ch_reg] <= v_reg;
                        ch_reg <= 1'b1;
                    end
                end
                A_DIV: begin
                    mean_reg[ch_reg] <= neg_reg ? -quo_val : quo_val;
                    ch_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            A_IDLE: item_reg <= item;
            A_READ: begin
                v_reg    <= v_cur;
                jump_reg <= jump_cur;
            end
            A_UPD: begin
                idx_reg  <= '0;
                neg_reg  <= sum_upd[SUM_W-1];
                mag_reg  <= sum_upd[SUM_W-1] ? MAG_W'($unsigned(-sum_upd))
                                             : MAG_W'($unsigned(sum_upd));
            end
            A_FILL: idx_reg <= idx_reg + 1'b1;
            A_OUT: begin
                if (out_load) begin
                    m_data_reg <= {2'b0, mean_reg[1][TEMP_W-1:0], mean_reg[0][PRES_W-1:0],
                                   item_reg.t, item_reg.p};
                    m_user_reg <= {item_reg.t_ok, item_reg.p_ok};
                end
            end
            default: ;
        endcase
    end

    assign item_ready = (state_reg == A_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser    = m_user_reg;

endmodule

`default_nettype wire

// File: sv/barometer_compensation_averager_unit.sv
// barometer_compensation_averager_unit: top level with configuration registers,
// compensation front, item queue and averaging back; depends on bca_pkg and all bca_ modules
`default_nettype none

// Each input transaction carries a raw pressure and temperature code; one output transaction
// follows with the compensated values, their in-range flags and both running averages. The
// front evaluates the calibration polynomial with a 4-bit digit-serial multiplier, seven
// products in turn, and at depth 16 it sets the pace. The back then, per channel, either
// refills the ring after a jump or forms the mean by a reciprocal multiplication; a
// two-entry queue lets the front start the next item meanwhile. Configuration writes take
// effect at once.
module barometer_compensation_averager_unit #(
    parameter int AVG_DEPTH = bca_pkg::AVG_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [bca_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [bca_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pressure_raw[15:0], temperature_raw[31:16]
    input  wire logic [bca_pkg::S_DATA_W-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // pressure[23:0], temperature[34:24], pressure_average[58:35],
    // temperature_average[69:59], zero fill[71:70]
    output logic [bca_pkg::M_DATA_W-1:0]           m_axis_tdata,
    // pressure_valid[0], temperature_valid[1]
    output logic [1:0]                             m_axis_tuser
);
    import bca_pkg::*;

    cfg_t  cfg_reg;
    item_t front_item, back_item;
    logic  front_valid, front_ready, back_valid, back_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sens        <= 16'd256;
            cfg_reg.offset      <= '0;
            cfg_reg.sens_temp   <= '0;
            cfg_reg.offset_temp <= '0;
            cfg_reg.ref_temp    <= 16'd4096;
            cfg_reg.temp_gain   <= '0;
            cfg_reg.pres_base   <= 12'd2400;
            cfg_reg.curve       <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_SENS:      cfg_reg.sens        <= cfg_wdata[15:0];
                REG_OFF:       cfg_reg.offset      <= cfg_wdata[12:0];
                REG_SENS_TEMP: cfg_reg.sens_temp   <= cfg_wdata[11:0];
                REG_OFF_TEMP:  cfg_reg.offset_temp <= cfg_wdata[12:0];
                REG_REF_TEMP:  cfg_reg.ref_temp    <= cfg_wdata[15:0];
                REG_TEMP_GAIN: cfg_reg.temp_gain   <= cfg_wdata[14:0];
                REG_PRES_BASE: cfg_reg.pres_base   <= cfg_wdata[11:0];
                REG_CURVE:     cfg_reg.curve       <= cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    bca_comp u_comp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .d1_in      (s_axis_tdata[15:0]),
        .d2_in      (s_axis_tdata[31:16]),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    bca_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_item  (front_item),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_item  (back_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    bca_avg #(.AVG_DEPTH(AVG_DEPTH)) u_avg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser)
    );

    a_pres_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[23:0] == 24'd0)
        else $error("pressure not zero while flagged out of range");

    a_temp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[34:24] == 11'd0)
        else $error("temperature not zero while flagged out of range");

    a_pres_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[23:0] <= 24'd10000000)
        else $error("pressure above full scale");

endmodule

`default_nettype wire
